@@ hw/rtl/icg_pkg.sv @@
// ----------------------------------------------------------------------------
// icg_pkg
// Shared types and constants of the iteration color gradient.
// ----------------------------------------------------------------------------
package icg_pkg;

  localparam int COUNT_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int LIMIT_BITS        = 16;
  localparam int CHAN_BITS         = 8;
  localparam int NUM_CHAN          = 3;
  localparam int NUM_STOPS         = 5;
  localparam int NUM_SEGS          = 4;
  localparam int RECIP_BITS        = 12;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd256;

  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  typedef logic [CHAN_BITS-1:0] chan_t;
  typedef logic [NUM_CHAN-1:0][CHAN_BITS-1:0] rgb_t;
  typedef logic [1:0] seg_t;
  typedef logic [2:0] stop_idx_t;

  localparam stop_idx_t LAST_STOP = stop_idx_t'(NUM_STOPS - 1);

  // packed as {blue, green, red}
  localparam rgb_t STOP_RGB [NUM_STOPS] = '{
    {8'd0,   8'd7,   8'd0},
    {8'd203, 8'd107, 8'd32},
    {8'd255, 8'd255, 8'd237},
    {8'd0,   8'd170, 8'd255},
    {8'd0,   8'd2,   8'd0}
  };

  typedef struct packed {
    logic valid;
    logic sat;
  } div_ctl_t;

endpackage

@@ hw/rtl/icg_divider.sv @@
// ----------------------------------------------------------------------------
// icg_divider
// Pipelined restoring divider: position = count * 2^FRACTION_BITS / limit,
// one quotient bit per stage; sat flag for count >= limit or a zero limit.
// ----------------------------------------------------------------------------
module icg_divider import icg_pkg::*; #(
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [COUNT_BITS-1:0]    count,
  input  logic [LIMIT_BITS-1:0]    limit,
  output logic [FRACTION_BITS-1:0] pos,
  output div_ctl_t                 ctl
);

  localparam int CW = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

  logic [CW-1:0] cnt_w;
  logic [CW-1:0] lim_w;
  logic          sat_in;

  logic                     vld   [FRACTION_BITS+1];
  logic                     sat   [FRACTION_BITS+1];
  logic [LIMIT_BITS-1:0]    rem   [FRACTION_BITS+1];
  logic [FRACTION_BITS-1:0] quo   [FRACTION_BITS+1];
  logic [LIMIT_BITS:0]      trial [FRACTION_BITS+1];
  logic                     fits  [FRACTION_BITS+1];

  assign cnt_w  = CW'(count);
  assign lim_w  = CW'(limit);
  assign sat_in = (limit == '0) || (cnt_w >= lim_w);

  always_comb begin
    trial[0] = '0;
    fits[0]  = 1'b0;
    for (int i = 1; i <= FRACTION_BITS; i++) begin
      trial[i] = {rem[i-1], 1'b0};
      fits[i]  = trial[i] >= {1'b0, limit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= FRACTION_BITS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i <= FRACTION_BITS; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sat[0] <= sat_in;
      rem[0] <= cnt_w[LIMIT_BITS-1:0];
      quo[0] <= '0;
      for (int i = 1; i <= FRACTION_BITS; i++) begin
        sat[i] <= sat[i-1];
        rem[i] <= fits[i] ? LIMIT_BITS'(trial[i] - {1'b0, limit})
                          : trial[i][LIMIT_BITS-1:0];
        quo[i] <= {quo[i-1][FRACTION_BITS-2:0], fits[i]};
      end
    end
  end

  assign pos       = quo[FRACTION_BITS];
  assign ctl.valid = vld[FRACTION_BITS];
  assign ctl.sat   = sat[FRACTION_BITS];

endmodule

@@ hw/rtl/icg_blend.sv @@
// ----------------------------------------------------------------------------
// icg_blend
// Segment select and per-channel linear interpolation; division by the
// segment width is a reciprocal multiply with a single correction step.
// ----------------------------------------------------------------------------
module icg_blend import icg_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [FRACTION_BITS-1:0] pos,
  input  div_ctl_t                 ctl,
  output logic                     color_valid,
  output rgb_t                     color
);

  localparam int FW = FRACTION_BITS;
  localparam int NW = FW + CHAN_BITS;
  localparam int PW = NW + RECIP_BITS;

  localparam logic [FW-1:0] BRK [NUM_STOPS] = '{
    '0,
    FW'(((64'd16   << FW) + 64'd50)   / 64'd100),
    FW'(((64'd42   << FW) + 64'd50)   / 64'd100),
    FW'(((64'd6425 << FW) + 64'd5000) / 64'd10000),
    FW'(((64'd8575 << FW) + 64'd5000) / 64'd10000)
  };

  localparam logic [FW-1:0] SEG_W [NUM_SEGS] = '{
    BRK[1] - BRK[0], BRK[2] - BRK[1], BRK[3] - BRK[2], BRK[4] - BRK[3]
  };

  localparam logic [RECIP_BITS-1:0] RECIP [NUM_SEGS] = '{
    RECIP_BITS'((64'd1 << NW) / 64'(SEG_W[0])),
    RECIP_BITS'((64'd1 << NW) / 64'(SEG_W[1])),
    RECIP_BITS'((64'd1 << NW) / 64'(SEG_W[2])),
    RECIP_BITS'((64'd1 << NW) / 64'(SEG_W[3]))
  };

  // stage 1: segment, offset, endpoints
  seg_t          seg_c;
  logic          last_c;
  logic [FW-1:0] d_c;
  stop_idx_t     from_idx;
  stop_idx_t     to_idx;
  chan_t         s_c   [NUM_CHAN];
  chan_t         mag_c [NUM_CHAN];
  logic          neg_c [NUM_CHAN];

  logic          v1, v2, v3, v4, v5, v6;
  seg_t          seg1, seg2, seg3, seg4, seg5;
  logic          last1, last2, last3, last4, last5;
  logic [FW-1:0] d1;
  chan_t         s1 [NUM_CHAN], s2 [NUM_CHAN], s3 [NUM_CHAN], s4 [NUM_CHAN], s5 [NUM_CHAN];
  logic          n1 [NUM_CHAN], n2 [NUM_CHAN], n3 [NUM_CHAN], n4 [NUM_CHAN], n5 [NUM_CHAN];
  chan_t         mag1 [NUM_CHAN];
  logic [NW-1:0] num2 [NUM_CHAN];
  logic [NW-1:0] num3 [NUM_CHAN];
  logic [NW-1:0] num4 [NUM_CHAN];
  chan_t         qe4  [NUM_CHAN];
  chan_t         qe5  [NUM_CHAN];
  logic [FW:0]   r5   [NUM_CHAN];
  rgb_t          col6;

  logic [PW-1:0] prod_c [NUM_CHAN];
  logic [NW-1:0] rem_c  [NUM_CHAN];
  chan_t         q_c    [NUM_CHAN];
  logic [CHAN_BITS:0] sum_c [NUM_CHAN];
  rgb_t          col_c;
  logic          wrap_any;
  logic          rem_ok;

  always_comb begin
    if (pos < BRK[1]) begin
      seg_c = 2'd0;
    end else if (pos < BRK[2]) begin
      seg_c = 2'd1;
    end else if (pos < BRK[3]) begin
      seg_c = 2'd2;
    end else begin
      seg_c = 2'd3;
    end
    last_c   = ctl.sat || (pos >= BRK[4]);
    from_idx = {1'b0, seg_c};
    to_idx   = from_idx + 3'd1;
    d_c      = last_c ? '0 : pos - BRK[from_idx];
    for (int l = 0; l < NUM_CHAN; l++) begin
      s_c[l]   = STOP_RGB[from_idx][l];
      neg_c[l] = STOP_RGB[to_idx][l] < STOP_RGB[from_idx][l];
      mag_c[l] = neg_c[l] ? STOP_RGB[from_idx][l] - STOP_RGB[to_idx][l]
                          : STOP_RGB[to_idx][l] - STOP_RGB[from_idx][l];
    end
  end

  always_comb begin
    wrap_any = 1'b0;
    rem_ok   = 1'b1;
    for (int l = 0; l < NUM_CHAN; l++) begin
      prod_c[l] = PW'(num3[l]) * PW'(RECIP[seg3]);
      rem_c[l]  = num4[l] - NW'(qe4[l]) * NW'(SEG_W[seg4]);
      q_c[l]    = qe5[l] + CHAN_BITS'(r5[l] >= {1'b0, SEG_W[seg5]});
      sum_c[l]  = n5[l] ? {1'b0, s5[l]} - {1'b0, q_c[l]}
                        : {1'b0, s5[l]} + {1'b0, q_c[l]};
      col_c[l]  = last5 ? STOP_RGB[LAST_STOP][l] : sum_c[l][CHAN_BITS-1:0];
      wrap_any  = wrap_any | sum_c[l][CHAN_BITS];
      rem_ok    = rem_ok & ((FW+2)'(r5[l]) < ((FW+2)'(SEG_W[seg5]) << 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else if (adv) begin
      {v1, v2, v3, v4, v5, v6} <= {ctl.valid, v1, v2, v3, v4, v5};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg1  <= seg_c;
      last1 <= last_c;
      d1    <= d_c;
      seg2  <= seg1;
      last2 <= last1;
      seg3  <= seg2;
      last3 <= last2;
      seg4  <= seg3;
      last4 <= last3;
      seg5  <= seg4;
      last5 <= last4;
      for (int l = 0; l < NUM_CHAN; l++) begin
        s1[l]   <= s_c[l];
        n1[l]   <= neg_c[l];
        mag1[l] <= mag_c[l];
        s2[l]   <= s1[l];
        n2[l]   <= n1[l];
        num2[l] <= NW'(mag1[l]) * NW'(d1);
        s3[l]   <= s2[l];
        n3[l]   <= n2[l];
        num3[l] <= num2[l] + (n2[l] ? NW'(SEG_W[seg2] - 1'b1) : '0);
        s4[l]   <= s3[l];
        n4[l]   <= n3[l];
        num4[l] <= num3[l];
        qe4[l]  <= prod_c[l][NW +: CHAN_BITS];
        s5[l]   <= s4[l];
        n5[l]   <= n4[l];
        qe5[l]  <= qe4[l];
        r5[l]   <= rem_c[l][FW:0];
      end
      col6 <= col_c;
    end
  end

  assign color_valid = v6;
  assign color       = col6;

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (v5 && !last5) |-> rem_ok)
    else $error("reciprocal estimate off by more than one");

  a_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (v5 && !last5) |-> !wrap_any)
    else $error("interpolated channel left 8-bit range");
`endif

endmodule

@@ hw/rtl/icg_skid.sv @@
// ----------------------------------------------------------------------------
// icg_skid
// Output register with one spare entry, so the pipeline can still hand over
// one more beat after the output stalls.
// ----------------------------------------------------------------------------
module icg_skid import icg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic room,
  input  rgb_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rgb_t out_data
);

  logic spare_valid;
  rgb_t spare;
  logic take;
  logic give;

  assign room = !spare_valid;
  assign take = in_valid && room;
  assign give = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (take) begin
      if (out_valid && out_stall) begin
        spare_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (give) begin
      if (spare_valid) begin
        spare_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (out_valid && out_stall) begin
        spare <= in_data;
      end else begin
        out_data <= in_data;
      end
    end else if (give && spare_valid) begin
      out_data <= spare;
    end
  end

`ifndef NO_ASSERTIONS
  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("spare entry held without an output beat");

  a_spare_drains: assert property (@(posedge clk) disable iff (rst)
    (spare_valid && !out_stall) |=> !spare_valid)
    else $error("spare entry not drained");
`endif

endmodule

@@ hw/rtl/iteration_color_gradient_top.sv @@
// ----------------------------------------------------------------------------
// iteration_color_gradient_top
// Maps an escape-iteration count to an RGB color on a five-stop gradient.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while in_stall is low and returns one color per
// beat, in order. The position count/limit comes from a restoring divider
// with one quotient bit per stage. A beat passes 1 entry stage,
// FRACTION_BITS divider stages, 6 interpolation stages and the output
// register. The output register has a spare entry; in_stall rises only once
// both are full. A count at or above iteration_limit, or a zero limit, gives
// the last stop. Write iteration_limit only while the block is empty.
module iteration_color_gradient_top import icg_pkg::*; #(
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  config_we,
  input  logic [LIMIT_BITS-1:0] config_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COUNT_BITS-1:0] iteration_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_BITS-1:0]  red,
  output logic [CHAN_BITS-1:0]  green,
  output logic [CHAN_BITS-1:0]  blue
);

  logic [LIMIT_BITS-1:0]    iteration_limit;
  logic                     adv;
  logic [FRACTION_BITS-1:0] pos;
  div_ctl_t                 div_ctl;
  logic                     color_valid;
  rgb_t                     color;
  rgb_t                     out_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= LIMIT_RESET;
    end else if (config_we) begin
      iteration_limit <= config_data;
    end
  end

  assign in_stall = !adv;

  icg_divider #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .count    (iteration_count),
    .limit    (iteration_limit),
    .pos      (pos),
    .ctl      (div_ctl)
  );

  icg_blend #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_blend (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .pos         (pos),
    .ctl         (div_ctl),
    .color_valid (color_valid),
    .color       (color)
  );

  icg_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (color_valid),
    .room      (adv),
    .in_data   (color),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_rgb)
  );

  assign red   = out_rgb[LANE_RED];
  assign green = out_rgb[LANE_GREEN];
  assign blue  = out_rgb[LANE_BLUE];

endmodule
